>>> rtl/assert_macros.svh
// assertion helpers, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/ddgtp_pkg.sv
`timescale 1ns / 1ps
package ddgtp_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CordicN = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int unsigned CntW = 5;
  localparam int unsigned DW = 34;
  localparam int unsigned ZW = 28;
  localparam int unsigned SqW = 50;
  localparam int unsigned RootW = 25;

  localparam logic signed [ZW-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [DW-1:0] CordicK = 34'sd652032874;
  localparam logic signed [15:0] EffDriveMax = 16'sd20480;
  localparam logic signed [15:0] EffDead = 16'sd1280;
  localparam logic signed [15:0] EffOutMax = 16'sd23040;
  localparam logic [SqW-1:0] ReachSq = 50'd262144;
  localparam logic [15:0] DriveGainRst = 16'd480;
  localparam logic [15:0] TurnGainRst = 16'd4000;

  typedef enum logic [1:0] {
    CFG_DEST_X, CFG_DEST_Y, CFG_DRIVE_GAIN, CFG_TURN_GAIN
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_CHK, S_DLT, S_ANG, S_ZMUL, S_ZSET, S_ROT,
    S_MCX, S_SX, S_SY, S_DIFF, S_RSET, S_RWAIT, S_VSET, S_VWAIT, S_ERRM,
    S_ERRS, S_DRVM, S_DRVS, S_TRNS, S_OUTS
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_cmd_t;

  // arctangent of 2^-i in Q24 radians
  function automatic logic signed [ZW-1:0] atan_entry(input logic [CntW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      default: r = 28'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

  // floor(u / 50) by reciprocal multiply and one correction
  function automatic logic [15:0] div50(input logic [20:0] u);
    logic [33:0] p;
    logic [15:0] q0;
    logic [21:0] q50;
    p = 34'(u) * 34'd5243;
    q0 = p[33:18];
    q50 = 22'({q0, 5'b0}) + 22'({q0, 4'b0}) + 22'({q0, 1'b0});
    return (q50 > 22'(u)) ? (q0 - 16'd1) : q0;
  endfunction

  // rounded (fs * trig) / (50 * 2^30)
  function automatic logic signed [15:0] pose_step(input logic signed [59:0] p);
    logic signed [59:0] s;
    logic signed [20:0] u;
    s = p + (60'sd25 <<< 30);
    u = 21'($signed(s[47:30])) + 21'sd51200;
    return $signed(div50(u) - 16'd1024);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'sd8388607) r = 24'sd8388607;
    else if (v < -25'sd8388608) r = -24'sd8388608;
    else r = $signed(v[23:0]);
    return r;
  endfunction

endpackage

>>> rtl/ddgtp_cordic.sv
`timescale 1ns / 1ps
module ddgtp_cordic import ddgtp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_cmd_t          cmd_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 done_o
);

  logic signed [DW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic                 vec_q, run_q, done_q, ccw, last;
  logic [CntW-1:0]      cnt_q;

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = atan_entry(cnt_q);
    // vectoring drives y to zero, rotation drives z to zero
    ccw = vec_q ? y_q[DW-1] : ~z_q[ZW-1];
    last = (cnt_q == CntW'(CordicN - 1));
    if (ccw) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
      vec_q <= cmd_i.vec;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && last;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        run_q <= !last;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign done_o = done_q;

endmodule

>>> rtl/ddgtp_isqrt.sv
`timescale 1ns / 1ps
module ddgtp_isqrt import ddgtp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   n_i,
  output logic [RootW-1:0] root_o,
  output logic             done_o
);

  logic [SqW-1:0] n_q, r_q, bit_q, n_d, r_d;
  logic [SqW:0]   sum;
  logic           run_q, done_q;

  always_comb begin
    sum = {1'b0, r_q} + {1'b0, bit_q};
    if ({1'b0, n_q} >= sum) begin
      n_d = n_q - sum[SqW-1:0];
      r_d = (r_q >> 1) + bit_q;
    end else begin
      n_d = n_q;
      r_d = r_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      r_q <= '0;
      bit_q <= {2'b01, {(SqW-2){1'b0}}};
    end else if (run_q) begin
      n_q <= n_d;
      r_q <= r_d;
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && bit_q[0];
      if (start_i) run_q <= 1'b1;
      else if (run_q && bit_q[0]) run_q <= 1'b0;
    end
  end

  assign root_o = r_q[RootW-1:0];
  assign done_o = done_q;

endmodule

>>> rtl/diff_drive_go_to_point.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// go-to-goal controller for a differential-drive robot, one transaction per control tick
// input channel: in_valid_i / in_stall_o carry forward_speed_i (Q8.8 cm/s) and
//   turn_rate_i (1/65536 turn per s); a transaction is taken when valid is high
//   and stall is low
// output channel: out_valid_o / out_stall_i carry left_effort_o, right_effort_o
//   (Q8.8, within +-90) and reached_o
// config: cfg_we_i writes cfg_data_i to the register picked by cfg_index_i
//   (0 dest_x, 1 dest_y, 2 drive_gain, 3 turn_gain); write only while idle
// sequence: a goal already reached goes from the range check straight to the
//   output; otherwise the sequencer walks one shared multiplier, the CORDIC
//   unit (sin/cos, then atan2) and the one-bit-per-cycle root unit
// throughput: one transaction at a time, in_stall_o is high from acceptance
//   until the result is in the output register
// reset: pose and heading go to zero, registers to their defaults, no
//   result pending
// receiver stall: the result holds in the output register; a new input is
//   still accepted and processed, and only its final write waits for the slot
module diff_drive_go_to_point import ddgtp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] forward_speed_i,
  input  logic signed [19:0] turn_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_effort_o,
  output logic signed [15:0] right_effort_o,
  output logic               reached_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  // configuration registers
  logic signed [23:0] dest_x_q, dest_y_q;
  logic [15:0]        drive_gain_q, turn_gain_q;

  // robot state
  logic signed [23:0] pose_x_q, pose_y_q;
  logic [15:0]        heading_q;

  seq_state_e state_q, state_d;

  // working registers
  logic signed [15:0] fs_q;
  logic signed [19:0] tr_q;
  logic signed [24:0] dx_q, dy_q;
  logic [SqW-1:0]     sq_q;
  logic               pass2_q, reach_q;
  logic signed [14:0] delta_q;
  logic signed [16:0] ang_q;
  logic               neg_q;
  logic signed [32:0] c_q, s_q;
  logic signed [ZW-1:0] zb_q, err_q;
  logic [RootW-1:0]   dist_q;
  logic signed [15:0] drive_q;
  logic signed [24:0] turn_q;
  logic signed [59:0] prod_q;

  // output register
  logic               out_valid_q, reached_q;
  logic signed [15:0] left_q, right_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [59:0] prod_d;

  // shared units
  cordic_cmd_t        cor_cmd;
  logic signed [DW-1:0] cor_x, cor_y, cor_xo, cor_yo;
  logic signed [ZW-1:0] cor_z, cor_zo;
  logic               cor_done, sq_start, sq_done;
  logic [RootW-1:0]   root;

  // datapath helpers
  logic               accept, out_free, vec_zero;
  logic signed [14:0] delta_d;
  logic [16:0]        a17;
  logic signed [16:0] ang_d;
  logic               neg_d;
  logic signed [59:0] zsum, hsum, dsum, tsum;
  logic signed [ZW-1:0] z0, hr;
  logic signed [28:0] e29;
  logic signed [ZW-1:0] err_d;
  logic signed [41:0] dv;
  logic signed [15:0] drive_d;
  logic signed [DW-1:0] x64, y64, vx0, vy0, cx, sx;
  logic signed [ZW-1:0] vz0;
  logic signed [25:0] ls, rs;
  logic signed [15:0] left_d, right_d;
  logic signed [20:0] tru;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign vec_zero = (dx_q == 25'sd0) && (dy_q == 25'sd0);
  assign prod_d = mul_a * mul_b;

  always_comb begin
    // heading step: round(turn_rate / 50), offset keeps the dividend positive
    tru = 21'(tr_q) + 21'sd819225;
    delta_d = 15'(div50(tru) - 16'd16384);

    // midpoint angle in 1/131072 turn, folded into the right half plane
    a17 = {heading_q, 1'b0} + 17'(delta_q);
    if (a17 >= 17'd32768 && a17 < 17'd98304) begin
      ang_d = $signed(a17 - 17'd65536);
      neg_d = 1'b1;
    end else begin
      ang_d = $signed(a17);
      neg_d = 1'b0;
    end

    // angle to Q24 radians
    zsum = prod_q + 60'sd32768;
    z0 = $signed(zsum[43:16]);

    cx = neg_q ? -cor_xo : cor_xo;
    sx = neg_q ? -cor_yo : cor_yo;

    // atan2 pre-rotation into the right half plane
    x64 = 34'(dx_q) <<< 6;
    y64 = 34'(dy_q) <<< 6;
    if (dx_q < 25'sd0) begin
      if (dy_q >= 25'sd0) begin
        vx0 = y64;
        vy0 = -x64;
        vz0 = HalfPiQ24;
      end else begin
        vx0 = -y64;
        vy0 = x64;
        vz0 = -HalfPiQ24;
      end
    end else begin
      vx0 = x64;
      vy0 = y64;
      vz0 = '0;
    end

    // heading error, wrapped to +-pi
    hsum = prod_q + 60'sd16384;
    hr = $signed(hsum[42:15]);
    e29 = 29'(zb_q) - 29'(hr);
    if (e29 > 29'(PiQ24)) e29 = e29 - 29'(PiQ24) - 29'(PiQ24);
    else if (e29 < -29'(PiQ24)) e29 = e29 + 29'(PiQ24) + 29'(PiQ24);
    err_d = e29[ZW-1:0];

    // drive effort with clamp and deadband
    dsum = prod_q + 60'sd8;
    dv = $signed(dsum[45:4]);
    if (dv > 42'(EffDriveMax)) drive_d = EffDriveMax;
    else if (dv < -42'(EffDriveMax)) drive_d = -EffDriveMax;
    else drive_d = dv[15:0];
    if (drive_d > -EffDead && drive_d < EffDead)
      drive_d = (drive_d > 16'sd0) ? EffDead : -EffDead;

    tsum = prod_q + 60'sd524288;

    // wheel efforts
    ls = 26'(drive_q) - 26'(turn_q);
    rs = 26'(drive_q) + 26'(turn_q);
    if (ls > 26'(EffOutMax)) left_d = EffOutMax;
    else if (ls < -26'(EffOutMax)) left_d = -EffOutMax;
    else left_d = ls[15:0];
    if (rs > 26'(EffOutMax)) right_d = EffOutMax;
    else if (rs < -26'(EffOutMax)) right_d = -EffOutMax;
    else right_d = rs[15:0];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SUM;
      S_SUM:   state_d = S_CHK;
      S_CHK: begin
        if (pass2_q) state_d = S_RSET;
        else if (sq_q < ReachSq) state_d = S_OUTS;
        else state_d = S_DLT;
      end
      S_DLT:   state_d = S_ANG;
      S_ANG:   state_d = S_ZMUL;
      S_ZMUL:  state_d = S_ZSET;
      S_ZSET:  state_d = S_ROT;
      S_ROT:   if (cor_done) state_d = S_MCX;
      S_MCX:   state_d = S_SX;
      S_SX:    state_d = S_SY;
      S_SY:    state_d = S_DIFF;
      S_DIFF:  state_d = S_SQX;
      S_RSET:  state_d = S_RWAIT;
      S_RWAIT: if (sq_done) state_d = S_VSET;
      S_VSET:  state_d = vec_zero ? S_ERRM : S_VWAIT;
      S_VWAIT: if (cor_done) state_d = S_ERRM;
      S_ERRM:  state_d = S_ERRS;
      S_ERRS:  state_d = S_DRVM;
      S_DRVM:  state_d = S_DRVS;
      S_DRVS:  state_d = S_TRNS;
      S_TRNS:  state_d = S_OUTS;
      S_OUTS:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and unit starts
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    mul_a = '0;
    mul_b = '0;
    cor_cmd = '0;
    cor_x = '0;
    cor_y = '0;
    cor_z = '0;
    sq_start = 1'b0;
    unique case (state_q)
      S_SQX: begin
        mul_a = 33'(dx_q);
        mul_b = 27'(dx_q);
      end
      S_SQY: begin
        mul_a = 33'(dy_q);
        mul_b = 27'(dy_q);
      end
      S_ZMUL: begin
        mul_a = 33'(ang_q);
        mul_b = 27'(PiQ24);
      end
      S_ZSET: begin
        cor_cmd.start = 1'b1;
        cor_x = CordicK;
        cor_z = z0;
      end
      S_MCX: begin
        mul_a = c_q;
        mul_b = 27'(fs_q);
      end
      S_SX: begin
        mul_a = s_q;
        mul_b = 27'(fs_q);
      end
      S_RSET: sq_start = 1'b1;
      S_VSET: begin
        cor_cmd.start = !vec_zero;
        cor_cmd.vec = 1'b1;
        cor_x = vx0;
        cor_y = vy0;
        cor_z = vz0;
      end
      S_ERRM: begin
        mul_a = 33'($signed(heading_q));
        mul_b = 27'(PiQ24);
      end
      S_DRVM: begin
        mul_a = $signed({8'd0, dist_q});
        mul_b = $signed({11'd0, drive_gain_q});
      end
      S_DRVS: begin
        mul_a = 33'(err_q);
        mul_b = $signed({11'd0, turn_gain_q});
      end
      default: ;
    endcase
  end

  // control state, robot state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass2_q <= 1'b0;
      reach_q <= 1'b0;
      out_valid_q <= 1'b0;
      pose_x_q <= '0;
      pose_y_q <= '0;
      heading_q <= '0;
      dest_x_q <= '0;
      dest_y_q <= '0;
      drive_gain_q <= DriveGainRst;
      turn_gain_q <= TurnGainRst;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_DEST_X:     dest_x_q <= $signed(cfg_data_i);
          CFG_DEST_Y:     dest_y_q <= $signed(cfg_data_i);
          CFG_DRIVE_GAIN: drive_gain_q <= cfg_data_i[15:0];
          CFG_TURN_GAIN:  turn_gain_q <= cfg_data_i[15:0];
        endcase
      end
      if (accept) pass2_q <= 1'b0;
      else if (state_q == S_DIFF) pass2_q <= 1'b1;
      if (state_q == S_CHK) reach_q <= !pass2_q && (sq_q < ReachSq);
      // heading advances once the midpoint sine and cosine are in hand
      if (state_q == S_ROT && cor_done) heading_q <= heading_q + 16'(delta_q);
      if (state_q == S_SX)
        pose_x_q <= sat24(25'(pose_x_q) + 25'(pose_step(prod_q)));
      if (state_q == S_SY)
        pose_y_q <= sat24(25'(pose_y_q) + 25'(pose_step(prod_q)));
      if (state_q == S_OUTS && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      fs_q <= forward_speed_i;
      tr_q <= turn_rate_i;
      dx_q <= 25'(dest_x_q) - 25'(pose_x_q);
      dy_q <= 25'(dest_y_q) - 25'(pose_y_q);
    end
    if (state_q == S_DIFF) begin
      dx_q <= 25'(dest_x_q) - 25'(pose_x_q);
      dy_q <= 25'(dest_y_q) - 25'(pose_y_q);
    end
    if (state_q == S_SQY) sq_q <= prod_q[SqW-1:0];
    if (state_q == S_SUM) sq_q <= sq_q + prod_q[SqW-1:0];
    if (state_q == S_DLT) delta_q <= delta_d;
    if (state_q == S_ANG) begin
      ang_q <= ang_d;
      neg_q <= neg_d;
    end
    if (state_q == S_ROT && cor_done) begin
      c_q <= cx[32:0];
      s_q <= sx[32:0];
    end
    if (state_q == S_RWAIT && sq_done) dist_q <= root;
    if (state_q == S_VSET && vec_zero) zb_q <= '0;
    if (state_q == S_VWAIT && cor_done) zb_q <= cor_zo;
    if (state_q == S_ERRS) err_q <= err_d;
    if (state_q == S_DRVS) drive_q <= drive_d;
    if (state_q == S_TRNS) turn_q <= $signed(tsum[44:20]);
    if (state_q == S_OUTS && out_free) begin
      if (reach_q) begin
        left_q <= '0;
        right_q <= '0;
        reached_q <= 1'b1;
      end else begin
        left_q <= left_d;
        right_q <= right_d;
        reached_q <= 1'b0;
      end
    end
  end

  ddgtp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .x_i    (cor_x),
    .y_i    (cor_y),
    .z_i    (cor_z),
    .x_o    (cor_xo),
    .y_o    (cor_yo),
    .z_o    (cor_zo),
    .done_o (cor_done)
  );

  ddgtp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (sq_q),
    .root_o  (root),
    .done_o  (sq_done)
  );

  assign out_valid_o = out_valid_q;
  assign left_effort_o = left_q;
  assign right_effort_o = right_q;
  assign reached_o = reached_q;

  // a reached result always carries zero efforts
  `ASSERT_PROP(a_reach_zero, clk_i, rst_ni, (out_valid_o && reached_o) |-> (left_effort_o == 16'sd0 && right_effort_o == 16'sd0))
  // a taken transaction keeps the input side stalled on the next cycle
  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // efforts never leave the saturation range
  `ASSERT_NEVER(a_eff_range, clk_i, rst_ni, out_valid_o && (left_effort_o > EffOutMax || left_effort_o < -EffOutMax || right_effort_o > EffOutMax || right_effort_o < -EffOutMax))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// go-to-goal controller testbench
// drives control ticks through the valid/stall input channel, keeps its own
// dead-reckoning and effort model and checks every effort transaction in order
module tb_top;
  import ddgtp_pkg::*;

  localparam int NSTEP = CordicN;
  localparam longint PI_Q = 52707179;
  localparam longint TRIG_GAIN = 652032874;
  localparam longint POS_MAX = 8388607;
  localparam longint POS_MIN = -8388608;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_WAIT = 150;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               at_goal;
  } effort_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] forward_speed_i = '0;
  logic signed [19:0] turn_rate_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] left_effort_o;
  logic signed [15:0] right_effort_o;
  logic               reached_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;

  diff_drive_go_to_point u_top (.*);

  always #5 clk_i = ~clk_i;

  // model state: robot pose, heading and the register file
  longint rb_x, rb_y, rb_hdg;
  longint goal_x, goal_y, k_drive, k_turn;

  effort_t effort_q[$];
  bit      failed;
  bit      idle_en;
  int      wdog;

  // ---------------------------------------------------------------------
  // fixed-point helpers
  // ---------------------------------------------------------------------
  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    return fdiv(n + d / 2, d);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // arctangent of 2^-i, radians in Q24
  function automatic longint atan_q24(int i);
    case (i)
      0: return 13176795;
      1: return 7778716;
      2: return 4110060;
      3: return 2086331;
      4: return 1047214;
      5: return 524117;
      6: return 262123;
      7: return 131069;
      default: return longint'(1) << (24 - i);
    endcase
  endfunction

  // angle in 1/131072 turn -> cos, sin in Q30 (with the CORDIC gain folded in)
  function automatic void cordic_rotate(input longint a, output longint c, output longint s);
    longint ang, x, y, z, t;
    bit neg;
    ang = a & 64'h1FFFF;
    neg = 1'b0;
    x = TRIG_GAIN;
    y = 0;
    if (ang >= 32768 && ang < 98304) begin
      neg = 1'b1;
      ang -= 65536;
    end else if (ang >= 98304) begin
      ang -= 131072;
    end
    z = rdiv(ang * PI_Q, 65536);
    for (int i = 0; i < NSTEP; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q24(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q24(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  // bearing of (dx, dy), radians Q24; zero vector gives zero
  function automatic longint cordic_bearing(longint dx, longint dy);
    longint x, y, z, t;
    x = dx * 64;
    y = dy * 64;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = PI_Q / 2;
      end else begin
        t = -y; y = x; x = t; z = -(PI_Q / 2);
      end
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q24(i);
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q24(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned range_sq(longint dx, longint dy);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  // pose after one tick of midpoint dead reckoning, without committing it
  function automatic void next_pose(input longint fs, input longint tr,
                                    output longint nx, output longint ny,
                                    output longint nh);
    longint delta, c, s;
    delta = rdiv(tr, 50);
    cordic_rotate(2 * rb_hdg + delta + 131072, c, s);
    nx = clampl(rb_x + rdiv(fs * c, longint'(50) << 30), POS_MIN, POS_MAX);
    ny = clampl(rb_y + rdiv(fs * s, longint'(50) << 30), POS_MIN, POS_MAX);
    nh = (rb_hdg + delta + 65536) & 64'hFFFF;
  endfunction

  // efforts for one tick; advances the model pose unless already at the goal
  function automatic effort_t steer_efforts(longint fs, longint tr);
    effort_t e;
    longint dx, dy, tgt, hs, err, drv, trn, span;
    e.left = '0;
    e.right = '0;
    e.at_goal = 1'b1;
    if (range_sq(goal_x - rb_x, goal_y - rb_y) < 262144) return e;
    next_pose(fs, tr, rb_x, rb_y, rb_hdg);
    dx = goal_x - rb_x;
    dy = goal_y - rb_y;
    span = longint'(int_root(range_sq(dx, dy)));
    tgt = cordic_bearing(dx, dy);
    hs = rb_hdg >= 32768 ? rb_hdg - 65536 : rb_hdg;
    err = tgt - rdiv(hs * PI_Q, 32768);
    if (err > PI_Q) err -= 2 * PI_Q;
    if (err < -PI_Q) err += 2 * PI_Q;
    drv = clampl(rdiv(span * k_drive, 16), -20480, 20480);
    // deadband: push to the nearer edge, zero goes negative
    if (drv > -1280 && drv < 1280) drv = drv > 0 ? 1280 : -1280;
    trn = rdiv(err * k_turn, longint'(1) << 20);
    e.left = 16'(clampl(drv - trn, -23040, 23040));
    e.right = 16'(clampl(drv + trn, -23040, 23040));
    e.at_goal = 1'b0;
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------
  task automatic send_tick(longint fs, longint tr);
    if (idle_en) repeat ($urandom_range(0, 11)) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    forward_speed_i <= 16'(fs);
    turn_rate_i <= 20'(tr);
    do @(posedge clk_i); while (in_stall_o);
    effort_q.push_back(steer_efforts(longint'($signed(forward_speed_i)),
                                     longint'($signed(turn_rate_i))));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender holds off until every expected transaction is back and the block is idle
  task automatic wait_drained();
    while (effort_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 24'(v);
    case (idx)
      CFG_DEST_X:     goal_x = longint'($signed(24'(v)));
      CFG_DEST_Y:     goal_y = longint'($signed(24'(v)));
      CFG_DRIVE_GAIN: k_drive = v & 64'hFFFF;
      CFG_TURN_GAIN:  k_turn = v & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(longint gx, longint gy, longint kd, longint kt);
    wait_drained();
    write_reg(CFG_DEST_X, gx);
    write_reg(CFG_DEST_Y, gy);
    write_reg(CFG_DRIVE_GAIN, kd);
    write_reg(CFG_TURN_GAIN, kt);
  endtask

  // receiver: random stall before each transaction, with no-stall stretches
  initial begin
    int k;
    forever begin
      @(negedge clk_i);
      k = idle_en ? $urandom_range(0, 11) : 0;
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    effort_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid_o && !out_stall_i) begin
        if (effort_q.size() == 0) begin
          $display("%0t unexpected transaction: left %0d right %0d reached %0b",
                   $time, left_effort_o, right_effort_o, reached_o);
          failed = 1'b1;
        end else begin
          e = effort_q.pop_front();
          if (left_effort_o !== e.left) begin
            $display("%0t left_effort exp %0d got %0d", $time, e.left, left_effort_o);
            failed = 1'b1;
          end
          if (right_effort_o !== e.right) begin
            $display("%0t right_effort exp %0d got %0d", $time, e.right, right_effort_o);
            failed = 1'b1;
          end
          if (reached_o !== e.at_goal) begin
            $display("%0t reached exp %0b got %0b", $time, e.at_goal, reached_o);
            failed = 1'b1;
          end
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("%0t timeout, %0d transactions outstanding", $time, effort_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // goal at the origin after reset: already reached, pose must not move
  task automatic test_reached_at_reset();
    send_tick(32767, 524287);
    send_tick(-32768, -524288);
    send_tick(0, 0);
  endtask

  // full-speed straight run along +x with no idling on either side
  task automatic test_straight_run();
    idle_en = 1'b0;
    set_config(POS_MIN, POS_MAX, 480, 4000);
    for (int i = 0; i < 400; i++) send_tick(32767, 0);
    send_tick(32767, 200);
    idle_en = 1'b1;
  endtask

  // input extremes, gain extremes and the deadband
  task automatic test_directed_extremes();
    set_config(POS_MAX, POS_MIN, 65535, 65535);
    send_tick(-32768, -524288);
    send_tick(32767, 524287);
    send_tick(0, 1);
    send_tick(1, -1);
    send_tick(-1, 25);
    send_tick(256, -25);
    // zero drive gain lands inside the deadband and goes to -5
    set_config(rb_x + 100000, rb_y - 3000, 0, 0);
    send_tick(2560, 3000);
    send_tick(-2560, -3000);
    // tiny positive drive goes to +5
    set_config(rb_x + 2000, rb_y, 1, 65535);
    send_tick(0, 0);
    send_tick(0, 100000);
  endtask

  // goal placed exactly where the next tick lands the robot
  task automatic test_goal_under_robot();
    longint nx, ny, nh;
    wait_drained();
    next_pose(32767, 0, nx, ny, nh);
    set_config(nx, ny, 480, 4000);
    send_tick(32767, 0);
    send_tick(1000, 5000);
  endtask

  // reach test at the 2 cm boundary, measured on the stored pose
  task automatic test_reach_boundary();
    set_config(rb_x + 511, rb_y, 480, 4000);
    send_tick(12800, 0);
    set_config(rb_x + 512, rb_y, 480, 4000);
    send_tick(0, 0);
    set_config(rb_x - 300, rb_y + 300, 480, 4000);
    send_tick(-32768, 777);
  endtask

  task automatic test_random_drive();
    longint gx, gy, kd, kt, fs, tr;
    for (int ph = 0; ph < 20; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          gx = longint'($signed(24'($urandom)));
          gy = longint'($signed(24'($urandom)));
        end
        1: begin
          // goal within reach of the current pose
          gx = rb_x + $signed($urandom_range(0, 600)) - 300;
          gy = rb_y + $signed($urandom_range(0, 600)) - 300;
        end
        default: begin
          gx = clampl(rb_x + $signed($urandom_range(0, 40000)) - 20000, POS_MIN, POS_MAX);
          gy = clampl(rb_y + $signed($urandom_range(0, 40000)) - 20000, POS_MIN, POS_MAX);
        end
      endcase
      kd = $urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 65535))
                                     : longint'($urandom_range(0, 64));
      kt = longint'($urandom_range(0, 65535));
      if (ph == 3) kd = 65535;
      if (ph == 4) kt = 0;
      set_config(gx, gy, kd, kt);
      for (int i = 0; i < 65; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          fs = longint'($signed(16'($urandom)));
          tr = longint'($signed(20'($urandom)));
        end else begin
          fs = $signed($urandom_range(0, 12800)) - 6400;
          tr = $signed($urandom_range(0, 40000)) - 20000;
        end
        send_tick(fs, tr);
      end
    end
  endtask

  initial begin
    rb_x = 0; rb_y = 0; rb_hdg = 0;
    goal_x = 0; goal_y = 0; k_drive = 480; k_turn = 4000;
    failed = 1'b0;
    idle_en = 1'b1;
    wdog = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reached_at_reset();
    test_straight_run();
    test_directed_extremes();
    test_goal_under_robot();
    test_reach_boundary();
    test_random_drive();

    wait_drained();
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
